// ===== hw/rtl/iau_pkg.sv =====
// package for the integer arithmetic unit: operation codes, widths, beat layout
// no dependencies
package iau_pkg;
	localparam int OperW = 31;
	localparam int DataW = 32;
	localparam int CntW  = 6;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_SUB  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_DIV  = 3'd3;
	localparam logic [2:0] OP_SQRT = 3'd4;
	localparam logic [2:0] OP_POW  = 3'd5;

	typedef struct packed {
		logic [OperW-1:0] operand_b;
		logic [OperW-1:0] operand_a;
		logic [2:0]       operation;
	} in_beat_t;
endpackage

// ===== hw/rtl/integer_arith_unit.sv =====
// integer arithmetic unit: add, subtract, multiply, divide, square root, power
// depends on iau_pkg
//
// One result beat per input beat, one beat in the unit at a time. The result is
// registered and passes through the done state before it is offered. Add,
// subtract, divide by zero and unused codes go to the done state at the
// accepting edge; multiply and divide first run one bit per cycle through shift
// registers, 32 steps, and square root one root bit per cycle, 16 steps. Power
// runs square-and-multiply, each multiply being a bit-serial shift-add: one
// square per exponent bit above the lowest and one multiply per set exponent bit,
// so an exponent of all ones takes 61 multiplies; exponent zero gives 1 directly.
// The next input beat is taken in the cycle after the result beat has been
// handed to the output.
module integer_arith_unit import iau_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // operation[2:0], operand_a[33:3], operand_b[64:34]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result_value[31:0]
	output logic        m_tuser    // divide_error
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_SQRT = 3'd3;
	localparam logic [2:0] ST_PMUL = 3'd4;
	localparam logic [2:0] ST_PSQ  = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	in_beat_t        in_beat;
	logic [2:0]      state_q;
	logic [CntW-1:0] cnt_q;
	logic [DataW-1:0] x_q;     // shifting multiplier / dividend / radicand
	logic [DataW-1:0] y_q;     // multiplicand / divisor
	logic [DataW-1:0] acc_q;   // product / quotient / root
	logic [DataW+1:0] rem_q;   // partial remainder
	logic [DataW-1:0] pacc_q;  // power accumulator
	logic [DataW-1:0] psq_q;   // power square
	logic [OperW-1:0] exp_q;
	logic [DataW-1:0] res_q;
	logic             err_q;
	logic             out_v_q;

	logic [DataW:0]   div_trial;
	logic [DataW+1:0] sq_rem;
	logic [DataW+1:0] sq_trial;
	logic [DataW-1:0] mul_next;

	assign in_beat  = in_beat_t'(s_tdata[64:0]);
	assign s_tready = (state_q == ST_IDLE) && !out_v_q;
	assign m_tvalid = out_v_q;
	assign m_tdata  = res_q;
	assign m_tuser  = err_q;

	// restoring divide step and square root step
	assign div_trial = {rem_q[DataW-1:0], x_q[DataW-1]} - {1'b0, y_q};
	assign sq_rem    = {rem_q[DataW-1:0], x_q[DataW-1:DataW-2]};
	assign sq_trial  = sq_rem - {acc_q, 2'b01};

	// shift-add step, partial product after the current multiplier bit
	assign mul_next  = x_q[0] ? acc_q + y_q : acc_q;

	// sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_v_q <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (out_v_q && m_tready) out_v_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid && s_tready) begin
						err_q <= (in_beat.operation == OP_DIV) && (in_beat.operand_b == '0);
						acc_q <= '0;
						rem_q <= '0;
						cnt_q <= '0;
						case (in_beat.operation)
							OP_ADD: begin
								res_q <= {1'b0, in_beat.operand_a} + {1'b0, in_beat.operand_b};
								state_q <= ST_DONE;
							end
							OP_SUB: begin
								res_q <= {1'b0, in_beat.operand_a} - {1'b0, in_beat.operand_b};
								state_q <= ST_DONE;
							end
							OP_MUL: begin
								x_q <= {1'b0, in_beat.operand_b};
								y_q <= {1'b0, in_beat.operand_a};
								state_q <= ST_MUL;
							end
							OP_DIV: begin
								if (in_beat.operand_b == '0) begin
									res_q <= '1;
									state_q <= ST_DONE;
								end else begin
									x_q <= {1'b0, in_beat.operand_a};
									y_q <= {1'b0, in_beat.operand_b};
									state_q <= ST_DIV;
								end
							end
							OP_SQRT: begin
								x_q <= {1'b0, in_beat.operand_a};
								state_q <= ST_SQRT;
							end
							OP_POW: begin
								pacc_q <= DataW'(1);
								psq_q  <= {1'b0, in_beat.operand_a};
								exp_q  <= in_beat.operand_b;
								if (in_beat.operand_b == '0) begin
									res_q <= DataW'(1);
									state_q <= ST_DONE;
								end else if (in_beat.operand_b[0]) begin
									x_q <= {1'b0, in_beat.operand_a};
									y_q <= DataW'(1);
									state_q <= ST_PMUL;
								end else begin
									x_q <= {1'b0, in_beat.operand_a};
									y_q <= {1'b0, in_beat.operand_a};
									state_q <= ST_PSQ;
								end
							end
							default: begin
								res_q <= '0;
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				// shift-add multiply, one multiplier bit per cycle, wraps at 32 bits
				ST_MUL, ST_PMUL, ST_PSQ: begin
					if (cnt_q != CntW'(DataW-1)) begin
						acc_q <= mul_next;
						x_q   <= x_q >> 1;
						y_q   <= y_q << 1;
						cnt_q <= cnt_q + 1'b1;
					end else begin
						cnt_q <= '0;
						acc_q <= '0;
						if (state_q == ST_MUL) begin
							res_q   <= mul_next;
							state_q <= ST_DONE;
						end else if (state_q == ST_PMUL) begin
							// accumulator updated; square next if more bits remain
							pacc_q <= mul_next;
							if (exp_q[OperW-1:1] == '0) begin
								res_q   <= mul_next;
								state_q <= ST_DONE;
							end else begin
								x_q     <= psq_q;
								y_q     <= psq_q;
								state_q <= ST_PSQ;
							end
						end else begin
							psq_q <= mul_next;
							exp_q <= exp_q >> 1;
							x_q   <= mul_next;
							if (exp_q[1]) begin
								y_q     <= pacc_q;
								state_q <= ST_PMUL;
							end else begin
								y_q     <= mul_next;
								state_q <= ST_PSQ;
							end
						end
					end
				end
				// restoring divide, one quotient bit per cycle
				ST_DIV: begin
					x_q   <= x_q << 1;
					cnt_q <= cnt_q + 1'b1;
					if (!div_trial[DataW]) begin
						rem_q <= {2'b00, div_trial[DataW-1:0]};
						acc_q <= {acc_q[DataW-2:0], 1'b1};
					end else begin
						rem_q <= {1'b0, rem_q[DataW-1:0], x_q[DataW-1]};
						acc_q <= {acc_q[DataW-2:0], 1'b0};
					end
					if (cnt_q == CntW'(DataW-1)) begin
						res_q   <= {acc_q[DataW-2:0], !div_trial[DataW]};
						state_q <= ST_DONE;
					end
				end
				// digit-by-digit square root, two radicand bits per cycle
				ST_SQRT: begin
					x_q   <= x_q << 2;
					cnt_q <= cnt_q + 1'b1;
					if (!sq_trial[DataW+1]) begin
						rem_q <= sq_trial;
						acc_q <= {acc_q[DataW-2:0], 1'b1};
					end else begin
						rem_q <= sq_rem;
						acc_q <= {acc_q[DataW-2:0], 1'b0};
					end
					if (cnt_q == CntW'(DataW/2-1)) begin
						res_q   <= {acc_q[DataW-2:0], !sq_trial[DataW+1]};
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					out_v_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// an accepted beat always starts work
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != ST_IDLE)
		else $error("accepted beat did not start work");
	// a result never appears while the unit is busy
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> state_q == ST_IDLE)
		else $error("result raised while busy");
	// error flag only with all-ones result
	a_err: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && err_q |-> res_q == '1)
		else $error("divide error without all-ones result");
`endif

endmodule
